// ----- src/nrg_pkg.sv -----
package nrg_pkg;

	localparam int unsigned BURST     = 8;
	localparam int unsigned TIME_W    = 48;
	localparam int unsigned REG_W     = 32;
	localparam int unsigned REQ_W     = 2;
	localparam int unsigned VERDICT_W = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned SLOT_W    = (BURST > 1) ? $clog2(BURST) : 1;
	localparam int unsigned CNT_W     = $clog2(BURST + 1);

	localparam logic [REG_W-1:0] WINDOW_RESET  = REG_W'(60000);
	localparam logic [REG_W-1:0] BACKOFF_RESET = REG_W'(30000);

	typedef enum logic [REQ_W-1:0] {
		REQ_CHECK   = 2'd0,
		REQ_FAIL    = 2'd1,
		REQ_SUCCESS = 2'd2
	} req_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_ALLOW   = 2'd0,
		VERDICT_BACKOFF = 2'd1,
		VERDICT_LIMITED = 2'd2
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW  = 1'd0,
		REG_BACKOFF = 1'd1
	} reg_idx_t;

endpackage

// ----- src/nrg_if.sv -----
interface nrg_req_if;
	logic                          valid;
	logic                          ready;
	logic [nrg_pkg::REQ_W-1:0]     req_type;
	logic [nrg_pkg::TIME_W-1:0]    now_ms;

	modport source (output valid, output req_type, output now_ms, input ready);
	modport sink   (input valid, input req_type, input now_ms, output ready);
endinterface

interface nrg_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [nrg_pkg::VERDICT_W-1:0] verdict;
	logic                          first_flag;

	modport source (output valid, output verdict, output first_flag, input ready);
	modport sink   (input valid, input verdict, input first_flag, output ready);
endinterface

// ----- src/notify_rate_gate_unit.sv -----
// Notify rate gate: sliding-window rate limiter with failure backoff.
// req channel: one transaction per request (req_type check/failed/succeeded,
// now_ms 48-bit timestamp). rsp channel: exactly one transaction per request,
// in order, carrying verdict and first_flag.
// Configuration: cfg_we writes cfg_data into window_ms (index 0) or
// backoff_ms (index 1); write only while no request is in flight.
// Flow: an accepted request is held in the input register; the decision
// logic then writes its result into the result register that drives rsp.
// Throughput: one request per cycle while rsp is not held off; the gate
// state and the 8-entry timestamp ring are updated in the same cycle as the
// decision, so the next request sees them immediately. The path is set by
// the 48-bit age subtract and window compare.
// Stall: while rsp is held off, one request waits in the input register and
// one result in the result register; req.ready drops only when both are full.
// Reset (arst_n low): the gate leaves failing state, the ring is empty,
// registers return to window 60000 ms and backoff 30000 ms, both channels
// are empty.
module notify_rate_gate_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	nrg_req_if.sink                         req,
	nrg_rsp_if.source                       rsp,
	input  logic                            cfg_we,
	input  logic [nrg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nrg_pkg::REG_W-1:0]       cfg_data
);

	localparam logic [nrg_pkg::CNT_W-1:0]  FULL_CNT  = nrg_pkg::CNT_W'(nrg_pkg::BURST);
	localparam logic [nrg_pkg::SLOT_W:0]   BURST_EXT = (nrg_pkg::SLOT_W + 1)'(nrg_pkg::BURST);
	localparam logic [nrg_pkg::SLOT_W-1:0] LAST_SLOT = nrg_pkg::SLOT_W'(nrg_pkg::BURST - 1);

	logic                            valid_s1;
	logic [nrg_pkg::REQ_W-1:0]       req_s1;
	logic [nrg_pkg::TIME_W-1:0]      now_s1;

	logic                            rsp_valid_q;
	nrg_pkg::verdict_t               verdict_q;
	logic                            first_q;

	logic [nrg_pkg::REG_W-1:0]       window_q;
	logic [nrg_pkg::REG_W-1:0]       backoff_q;

	logic [nrg_pkg::TIME_W-1:0]      ring_q [nrg_pkg::BURST];
	logic [nrg_pkg::SLOT_W-1:0]      oldest_q;
	logic [nrg_pkg::CNT_W-1:0]       held_q;
	logic                            failing_q;
	logic [nrg_pkg::TIME_W-1:0]      backoff_end_q;
	logic                            backoff_told_q;
	logic                            limit_told_q;

	logic [nrg_pkg::SLOT_W-1:0]      oldest_d;
	logic [nrg_pkg::CNT_W-1:0]       held_d;
	logic                            failing_d;
	logic [nrg_pkg::TIME_W-1:0]      backoff_end_d;
	logic                            backoff_told_d;
	logic                            limit_told_d;
	logic                            ring_we;
	logic [nrg_pkg::SLOT_W-1:0]      ring_wa;
	nrg_pkg::verdict_t               verdict_d;
	logic                            first_d;

	logic                            advance;
	logic                            full;
	logic [nrg_pkg::TIME_W-1:0]      age;
	logic [nrg_pkg::SLOT_W:0]        tail_sum;
	logic [nrg_pkg::SLOT_W-1:0]      tail_slot;
	logic [nrg_pkg::SLOT_W-1:0]      oldest_next;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.verdict    = verdict_q;
	assign rsp.first_flag = first_q;

	assign full        = (held_q == FULL_CNT);
	assign age         = now_s1 - ring_q[oldest_q];
	assign tail_sum    = {1'b0, oldest_q} + {1'b0, held_q[nrg_pkg::SLOT_W-1:0]};
	assign tail_slot   = (tail_sum >= BURST_EXT) ? nrg_pkg::SLOT_W'(tail_sum - BURST_EXT)
	                                             : tail_sum[nrg_pkg::SLOT_W-1:0];
	assign oldest_next = (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;

	always_comb begin
		oldest_d       = oldest_q;
		held_d         = held_q;
		failing_d      = failing_q;
		backoff_end_d  = backoff_end_q;
		backoff_told_d = backoff_told_q;
		limit_told_d   = limit_told_q;
		ring_we        = 1'b0;
		ring_wa        = tail_slot;
		verdict_d      = nrg_pkg::VERDICT_ALLOW;
		first_d        = 1'b0;
		unique case (req_s1)
			nrg_pkg::REQ_CHECK: begin
				if (failing_q && (now_s1 < backoff_end_q)) begin
					verdict_d      = nrg_pkg::VERDICT_BACKOFF;
					first_d        = !backoff_told_q;
					backoff_told_d = 1'b1;
				end else if (full &&
						(age < {{(nrg_pkg::TIME_W - nrg_pkg::REG_W){1'b0}}, window_q})) begin
					verdict_d    = nrg_pkg::VERDICT_LIMITED;
					first_d      = !limit_told_q;
					limit_told_d = 1'b1;
				end else begin
					ring_we = 1'b1;
					if (full) begin
						ring_wa  = oldest_q;
						oldest_d = oldest_next;
					end else begin
						held_d = held_q + 1'b1;
					end
					limit_told_d   = 1'b0;
					backoff_told_d = 1'b0;
				end
			end
			nrg_pkg::REQ_FAIL: begin
				first_d        = !failing_q;
				failing_d      = 1'b1;
				backoff_end_d  = now_s1 + {{(nrg_pkg::TIME_W - nrg_pkg::REG_W){1'b0}}, backoff_q};
				backoff_told_d = 1'b0;
			end
			nrg_pkg::REQ_SUCCESS: begin
				first_d       = failing_q;
				failing_d     = 1'b0;
				backoff_end_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			rsp_valid_q    <= 1'b0;
			window_q       <= nrg_pkg::WINDOW_RESET;
			backoff_q      <= nrg_pkg::BACKOFF_RESET;
			oldest_q       <= '0;
			held_q         <= '0;
			failing_q      <= 1'b0;
			backoff_end_q  <= '0;
			backoff_told_q <= 1'b0;
			limit_told_q   <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					nrg_pkg::REG_WINDOW:  window_q  <= cfg_data;
					nrg_pkg::REG_BACKOFF: backoff_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (advance) begin
				oldest_q       <= oldest_d;
				held_q         <= held_d;
				failing_q      <= failing_d;
				backoff_end_q  <= backoff_end_d;
				backoff_told_q <= backoff_told_d;
				limit_told_q   <= limit_told_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.req_type;
			now_s1 <= req.now_ms;
		end
		if (advance) begin
			verdict_q <= verdict_d;
			first_q   <= first_d;
			if (ring_we) begin
				ring_q[ring_wa] <= now_s1;
			end
		end
	end

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FULL_CNT)
		else $error("held count beyond ring depth");

	a_oldest_zero_until_full: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (oldest_q == '0))
		else $error("oldest slot moved before ring filled");

	a_allow_clears_told: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_s1 == nrg_pkg::REQ_CHECK) && (verdict_d == nrg_pkg::VERDICT_ALLOW))
		|=> (!limit_told_q && !backoff_told_q))
		else $error("allowed check left a denial marked as told");

	a_backoff_needs_failing: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (verdict_d == nrg_pkg::VERDICT_BACKOFF)) |-> failing_q)
		else $error("backoff denial while not failing");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> (rsp_valid_q && $stable(verdict_q) && $stable(first_q)))
		else $error("stalled result overwritten");
`endif

endmodule

// ----- sim/notify_rate_gate_unit_tb.sv -----
`timescale 1ns / 100ps

module notify_rate_gate_unit_tb;

	localparam logic [nrg_pkg::REQ_W-1:0] REQ_UNUSED     = 2'd3;
	localparam int                        RSP_LAT        = 2;
	localparam int                        WATCHDOG_LIMIT = 2000;
	localparam int                        REPORT_LIMIT   = 10;

	typedef struct packed {
		nrg_pkg::verdict_t verdict;
		logic              first;
	} gate_answer_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [nrg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [nrg_pkg::REG_W-1:0] cfg_data;

	nrg_req_if req_ch ();
	nrg_rsp_if rsp_ch ();

	notify_rate_gate_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// gate model state
	logic [nrg_pkg::REG_W-1:0]  gate_window;
	logic [nrg_pkg::REG_W-1:0]  gate_backoff;
	logic [nrg_pkg::TIME_W-1:0] gate_stamps [nrg_pkg::BURST];
	logic [nrg_pkg::SLOT_W-1:0] gate_oldest;
	logic [nrg_pkg::CNT_W-1:0]  gate_held;
	logic                       gate_failing;
	logic [nrg_pkg::TIME_W-1:0] gate_backoff_end;
	logic                       gate_backoff_told;
	logic                       gate_limit_told;

	gate_answer_t               pending_answers [$];
	int                         mismatches;
	int                         answers_seen;
	int                         quiet_cycles;
	int unsigned                src_idle_pct;
	int unsigned                snk_stall_pct;
	logic [nrg_pkg::TIME_W-1:0] stamp_now;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic gate_answer_t gate_decide(input logic [nrg_pkg::REQ_W-1:0] kind,
			input logic [nrg_pkg::TIME_W-1:0] t);
		gate_answer_t               ans;
		logic [nrg_pkg::TIME_W-1:0] age;
		logic [nrg_pkg::SLOT_W-1:0] slot;
		ans.verdict = nrg_pkg::VERDICT_ALLOW;
		ans.first   = 1'b0;
		unique case (kind)
			nrg_pkg::REQ_CHECK: begin
				if (gate_failing && t < gate_backoff_end) begin
					ans.verdict       = nrg_pkg::VERDICT_BACKOFF;
					ans.first         = !gate_backoff_told;
					gate_backoff_told = 1'b1;
				end else if (gate_held == nrg_pkg::CNT_W'(nrg_pkg::BURST)) begin
					age = t - gate_stamps[gate_oldest];
					if (age < {{(nrg_pkg::TIME_W-nrg_pkg::REG_W){1'b0}}, gate_window}) begin
						ans.verdict     = nrg_pkg::VERDICT_LIMITED;
						ans.first       = !gate_limit_told;
						gate_limit_told = 1'b1;
					end else begin
						gate_stamps[gate_oldest] = t;
						gate_oldest              = gate_oldest + 1'b1;
						gate_limit_told          = 1'b0;
						gate_backoff_told        = 1'b0;
					end
				end else begin
					slot              = gate_oldest + gate_held[nrg_pkg::SLOT_W-1:0];
					gate_stamps[slot] = t;
					gate_held         = gate_held + 1'b1;
					gate_limit_told   = 1'b0;
					gate_backoff_told = 1'b0;
				end
			end
			nrg_pkg::REQ_FAIL: begin
				ans.first         = !gate_failing;
				gate_failing      = 1'b1;
				gate_backoff_end  = t + {{(nrg_pkg::TIME_W-nrg_pkg::REG_W){1'b0}}, gate_backoff};
				gate_backoff_told = 1'b0;
			end
			nrg_pkg::REQ_SUCCESS: begin
				ans.first        = gate_failing;
				gate_failing     = 1'b0;
				gate_backoff_end = '0;
			end
			default: begin
			end
		endcase
		return ans;
	endfunction

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		gate_answer_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				pending_answers.push_back(gate_decide(req_ch.req_type, req_ch.now_ms));
			if (rsp_ch.valid && rsp_ch.ready) begin
				answers_seen++;
				if (pending_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result %0d with no request outstanding: verdict %0d first %0b",
							answers_seen, rsp_ch.verdict, rsp_ch.first_flag);
				end else begin
					want = pending_answers.pop_front();
					if (rsp_ch.verdict !== want.verdict || rsp_ch.first_flag !== want.first) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"result %0d: expected verdict %0d first %0b, ",
								"got verdict %0d first %0b"},
								answers_seen, want.verdict, want.first,
								rsp_ch.verdict, rsp_ch.first_flag);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("** notify_rate_gate_unit: FAILED **");
				$finish;
			end
		end
	end

	function automatic logic [nrg_pkg::TIME_W-1:0] random_stamp();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[nrg_pkg::TIME_W-1:0];
	endfunction

	task automatic send_req(input logic [nrg_pkg::REQ_W-1:0] kind,
			input logic [nrg_pkg::TIME_W-1:0] t);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.now_ms   <= t;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
		repeat (RSP_LAT + 2) @(negedge clk);
	endtask

	task automatic write_reg(input nrg_pkg::reg_idx_t idx,
			input logic [nrg_pkg::REG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == nrg_pkg::REG_WINDOW)
			gate_window = value;
		else
			gate_backoff = value;
		@(negedge clk);
	endtask

	task automatic drive_traffic(input int n, input int unsigned step_max);
		logic [nrg_pkg::REQ_W-1:0] kind;
		int unsigned               pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 70)
				kind = nrg_pkg::REQ_CHECK;
			else if (pick < 82)
				kind = nrg_pkg::REQ_FAIL;
			else if (pick < 96)
				kind = nrg_pkg::REQ_SUCCESS;
			else
				kind = REQ_UNUSED;
			if ($urandom_range(99) < 5)
				stamp_now = random_stamp();
			else
				stamp_now = stamp_now + nrg_pkg::TIME_W'($urandom_range(step_max));
			send_req(kind, stamp_now);
			if ($urandom_range(99) == 0)
				drain();
		end
	endtask

	task automatic test_directed();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		send_req(nrg_pkg::REQ_CHECK, '0);
		send_req(nrg_pkg::REQ_FAIL, 48'd100);
		send_req(nrg_pkg::REQ_CHECK, 48'd200);
		send_req(nrg_pkg::REQ_CHECK, 48'd300);
		send_req(nrg_pkg::REQ_FAIL, 48'd400);
		send_req(nrg_pkg::REQ_CHECK, 48'd500);
		send_req(nrg_pkg::REQ_SUCCESS, 48'd600);
		send_req(nrg_pkg::REQ_SUCCESS, 48'd700);
		send_req(REQ_UNUSED, '1);
		for (int i = 0; i < 7; i++)
			send_req(nrg_pkg::REQ_CHECK, 48'd800 + 48'(i * 100));
		send_req(nrg_pkg::REQ_CHECK, 48'd1500);
		send_req(nrg_pkg::REQ_CHECK, 48'd1600);
		send_req(nrg_pkg::REQ_CHECK, 48'd60000);
		send_req(nrg_pkg::REQ_FAIL, '1 - 48'd9);
		send_req(nrg_pkg::REQ_CHECK, '1 - 48'd4);
		send_req(nrg_pkg::REQ_CHECK, '0);
		send_req(nrg_pkg::REQ_SUCCESS, '1);
		drain();
	endtask

	task automatic test_registers();
		logic [nrg_pkg::REG_W-1:0] windows  [5];
		logic [nrg_pkg::REG_W-1:0] backoffs [5];
		windows  = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, $urandom()};
		backoffs = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, $urandom()};
		src_idle_pct  = 22;
		snk_stall_pct = 22;
		for (int s = 0; s < 5; s++) begin
			write_reg(nrg_pkg::REG_WINDOW, windows[s]);
			write_reg(nrg_pkg::REG_BACKOFF, backoffs[s]);
			stamp_now = random_stamp();
			drive_traffic(40, 4);
			drain();
		end
		write_reg(nrg_pkg::REG_WINDOW, nrg_pkg::WINDOW_RESET);
		write_reg(nrg_pkg::REG_BACKOFF, nrg_pkg::BACKOFF_RESET);
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
			input bit near_wrap);
		logic [nrg_pkg::REG_W-1:0] window;
		window = nrg_pkg::REG_W'($urandom_range(64, 4096));
		write_reg(nrg_pkg::REG_WINDOW, window);
		write_reg(nrg_pkg::REG_BACKOFF, nrg_pkg::REG_W'($urandom_range(16, 2048)));
		src_idle_pct  = idle_pct;
		snk_stall_pct = stall_pct;
		stamp_now = near_wrap ? ('1 - nrg_pkg::TIME_W'($urandom_range(20000)))
		                      : random_stamp();
		drive_traffic(270, window / 4);
		drain();
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = nrg_pkg::REG_WINDOW;
		cfg_data        = '0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = nrg_pkg::REQ_CHECK;
		req_ch.now_ms   = '0;
		rsp_ch.ready    = 1'b0;
		src_idle_pct    = 0;
		snk_stall_pct   = 0;
		mismatches      = 0;
		answers_seen    = 0;
		quiet_cycles    = 0;
		stamp_now       = '0;

		gate_window       = nrg_pkg::WINDOW_RESET;
		gate_backoff      = nrg_pkg::BACKOFF_RESET;
		gate_oldest       = '0;
		gate_held         = '0;
		gate_failing      = 1'b0;
		gate_backoff_end  = '0;
		gate_backoff_told = 1'b0;
		gate_limit_told   = 1'b0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_registers();
		test_random_traffic(0, 0, 1'b0);
		test_random_traffic(58, 0, 1'b1);
		test_random_traffic(0, 58, 1'b0);
		test_random_traffic(22, 22, 1'b0);

		drain();
		repeat (4 * RSP_LAT) @(negedge clk);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("** notify_rate_gate_unit: PASSED **");
		end else begin
			$display("** notify_rate_gate_unit: FAILED **");
		end
		$finish;
	end

endmodule

// ----- notify_rate_gate_unit.f -----
src/nrg_pkg.sv
src/nrg_if.sv
src/notify_rate_gate_unit.sv
sim/notify_rate_gate_unit_tb.sv
